/* sv/indexed_ordered_list_macros.svh */
// ----------------------------------------------------------------------------
// Indexed ordered list assertion macros
// Shared concurrent assertion helpers for the indexed ordered list block.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ORDERED_LIST_MACROS_SVH
`define INDEXED_ORDERED_LIST_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define IOL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("indexed_ordered_list assertion failed");
// Next-cycle implication, disabled while reset is high.
`define IOL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("indexed_ordered_list assertion failed");
`else
`define IOL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define IOL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/iol_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed ordered list package
// Sizes, command and status codes, and the cell operation type.
// ----------------------------------------------------------------------------
package iol_pkg;

   // Storage size and word width.
   localparam int DEPTH      = 16;
   localparam int WORD_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [CNT_W-1:0]      count_type;

   // Command codes.
   typedef enum logic [2:0] {
      FUNC_APPEND  = 3'd0,
      FUNC_PREPEND = 3'd1,
      FUNC_READ    = 3'd2,
      FUNC_FIND    = 3'd3,
      FUNC_REMOVE  = 3'd4
   } func_type;

   // Response status codes.
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_RANGE     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   // What a cell loads at the next edge.
   typedef enum logic [1:0] {
      CELL_HOLD      = 2'd0,
      CELL_LOAD      = 2'd1,
      CELL_FROM_PREV = 2'd2,
      CELL_FROM_NEXT = 2'd3
   } cell_op_type;

endpackage

/* sv/iol_cell.sv */
// ----------------------------------------------------------------------------
// Indexed ordered list cell
// Holds one list entry, shifts with its neighbors and compares against a key.
// ----------------------------------------------------------------------------
module iol_cell (
   input  logic                 clock,
   input  iol_pkg::cell_op_type op,
   input  iol_pkg::word_type    new_word,
   input  iol_pkg::word_type    prev_word,
   input  iol_pkg::word_type    next_word,
   input  iol_pkg::word_type    key,
   output iol_pkg::word_type    word,
   output logic                 match
);
   import iol_pkg::*;

   word_type word_ff;
   word_type word_in;

   // Select the next content of this entry.
   always_comb begin
      case (op)
         CELL_LOAD:      word_in = new_word;
         CELL_FROM_PREV: word_in = prev_word;
         CELL_FROM_NEXT: word_in = next_word;
         default:        word_in = word_ff;
      endcase
   end

   // Entry storage; contents are undefined until written.
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word  = word_ff;
   assign match = (word_ff == key);

endmodule

/* sv/indexed_ordered_list.sv */
// ----------------------------------------------------------------------------
// Indexed ordered list
// Bounded ordered word store with append, prepend, read, find and remove.
// ----------------------------------------------------------------------------
// The list is a row of DEPTH cells, one entry each; a prepend shifts every
// cell one place toward the back and a remove shifts the cells at and behind
// the index one place toward the front, all at the same edge. Each command
// is decoded against the current cells and count; the response lands in an
// output register and the cells update at the same edge. A new command is
// taken in every cycle in which the output register is empty or its
// response is being transferred, so the sustained rate is one command per
// cycle.
`include "indexed_ordered_list_macros.svh"

module indexed_ordered_list (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [3:0]  req_position,
   input  logic [31:0] req_word_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_word_out,
   output logic [4:0]  rsp_index_out,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_count_out
);
   import iol_pkg::*;

   word_type    cell_word [DEPTH];
   logic        cell_match [DEPTH];
   cell_op_type cell_op [DEPTH];
   word_type    key;

   count_type   count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_out_ff, rsp_word_out_in;
   logic [4:0]  rsp_index_out_ff, rsp_index_out_in;
   status_type  rsp_status_ff, rsp_status_in;

   logic        fire;
   logic        full;
   logic        in_range;
   logic        hit;
   count_type   hit_idx;
   count_type   pos_ext;

   assign key       = req_word_in[WORD_WIDTH-1:0];
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pos_ext   = CNT_W'(req_position);
   assign in_range  = (pos_ext < count_ff);

   // Row of cells; the front cell takes the new word on a prepend.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      iol_cell u_cell (
         .clock     (clock),
         .op        (cell_op[i]),
         .new_word  (key),
         .prev_word ((i == 0) ? key : cell_word[(i == 0) ? 0 : i - 1]),
         .next_word ((i == DEPTH - 1) ? cell_word[i]
                                      : cell_word[(i == DEPTH - 1) ? i : i + 1]),
         .key       (key),
         .word      (cell_word[i]),
         .match     (cell_match[i])
      );
   end

   // First valid cell that matches the key.
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (cell_match[i] && (CNT_W'(i) < count_ff)) begin
            hit     = 1'b1;
            hit_idx = CNT_W'(i);
         end
      end
   end

   // Per-cell operation for the accepted command.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_op[i] = CELL_HOLD;
         if (fire) begin
            case (func_type'(req_func))
               FUNC_APPEND: begin
                  if (!full && (CNT_W'(i) == count_ff)) cell_op[i] = CELL_LOAD;
               end
               FUNC_PREPEND: begin
                  if (!full) cell_op[i] = (i == 0) ? CELL_LOAD : CELL_FROM_PREV;
               end
               FUNC_REMOVE: begin
                  if (in_range && (CNT_W'(i) >= pos_ext)) cell_op[i] = CELL_FROM_NEXT;
               end
               default: cell_op[i] = CELL_HOLD;
            endcase
         end
      end
   end

   // Response and count for the accepted command.
   always_comb begin
      count_in         = count_ff;
      rsp_word_out_in  = '0;
      rsp_index_out_in = '0;
      rsp_status_in    = STAT_OK;
      case (func_type'(req_func))
         FUNC_APPEND, FUNC_PREPEND: begin
            if (full) rsp_status_in = STAT_FULL;
            else      count_in      = count_ff + 1'b1;
         end
         FUNC_READ: begin
            if (in_range) rsp_word_out_in = 32'(cell_word[req_position]);
            else          rsp_status_in   = STAT_RANGE;
         end
         FUNC_FIND: begin
            if (hit) begin
               rsp_index_out_in = 5'(hit_idx);
            end else begin
               rsp_index_out_in = 5'(count_ff);
               rsp_status_in    = STAT_NOT_FOUND;
            end
         end
         FUNC_REMOVE: begin
            if (in_range) begin
               rsp_word_out_in = 32'(cell_word[req_position]);
               count_in        = count_ff - 1'b1;
            end else begin
               rsp_status_in = STAT_RANGE;
            end
         end
         default: count_in = count_ff;
      endcase
   end

   // Output valid: set by a new command, cleared when the transfer completes.
   always_comb begin
      if (fire)           rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) count_ff <= count_in;
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_word_out_ff  <= rsp_word_out_in;
         rsp_index_out_ff <= rsp_index_out_in;
         rsp_status_ff    <= rsp_status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word_out  = rsp_word_out_ff;
   assign rsp_index_out = rsp_index_out_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count_out = 5'(count_ff);

   // Checks on count bookkeeping and response timing.
   `IOL_ASSERT_IMPL(a_count_max, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `IOL_ASSERT_NEXT(a_rsp_after_fire, clock, reset, fire, rsp_valid)
   `IOL_ASSERT_IMPL(a_full_means_full, clock, reset, rsp_valid && (rsp_status_ff == STAT_FULL), count_ff == CNT_W'(DEPTH))
   `IOL_ASSERT_NEXT(a_append_grows, clock, reset, fire && (req_func == FUNC_APPEND) && !full, count_ff == $past(count_ff) + 1'b1)

endmodule
